/* rtl/stopwatch_with_lap_core_macros.svh */
// Assertion helpers shared by the stopwatch RTL.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef STOPWATCH_WITH_LAP_CORE_MACROS_SVH
`define STOPWATCH_WITH_LAP_CORE_MACROS_SVH

// Same-cycle implication.
`define SWL_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("stopwatch check failed");

// Next-cycle implication.
`define SWL_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("stopwatch check failed");

`endif

/* rtl/swl_pkg.sv */
`timescale 1ns / 1ps

package swl_pkg;

    localparam int DIGIT_W   = 7;
    localparam int NUM_CELLS = 3;

    // Largest value held by each cell, lowest cell first:
    // centiseconds, seconds, minutes.
    localparam logic [DIGIT_W-1:0] CELL_MAX [NUM_CELLS] = '{
        DIGIT_W'(99), DIGIT_W'(59), DIGIT_W'(99)
    };

    localparam int CELL_CS = 0;
    localparam int CELL_SS = 1;
    localparam int CELL_MM = 2;

    // Per-word control handed to every cell.
    typedef struct packed {
        logic en;     // word accepted this cycle
        logic lap;    // capture stepped value into lap digit
        logic clear;  // zero count and lap digit
    } t_cell_ctl;

endpackage

/* rtl/swl_cell.sv */
`timescale 1ns / 1ps
`include "stopwatch_with_lap_core_macros.svh"

// One counter digit plus its lap copy. Takes a carry from the lower
// neighbor and hands its own carry to the upper one.
module swl_cell import swl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [DIGIT_W-1:0] i_max,
    input  logic               i_carry,
    output logic               o_carry,
    output logic [DIGIT_W-1:0] o_digit,
    output logic [DIGIT_W-1:0] o_lap
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] r_lap;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] n_lap;
    logic [DIGIT_W-1:0] w_stepped;
    logic               w_at_max;

    assign w_at_max  = (r_digit == i_max);
    assign o_carry   = i_carry && w_at_max;
    assign w_stepped = !i_carry ? r_digit :
                       (w_at_max ? '0 : r_digit + DIGIT_W'(1));

    always_comb begin
        n_digit = r_digit;
        n_lap   = r_lap;
        if (i_ctl.en) begin
            n_digit = w_stepped;
            if (i_ctl.lap) begin
                n_lap = w_stepped;
            end
            if (i_ctl.clear) begin
                n_digit = '0;
                n_lap   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
            r_lap   <= '0;
        end else begin
            r_digit <= n_digit;
            r_lap   <= n_lap;
        end
    end

    assign o_digit = r_digit;
    assign o_lap   = r_lap;

    `SWL_ASSERT_IMP(a_digit_range, 1'b1, r_digit <= i_max && r_lap <= i_max)
    `SWL_ASSERT_NXT(a_hold_idle, !i_ctl.en, $stable(r_digit) && $stable(r_lap))
    `SWL_ASSERT_IMP(a_carry_only_at_max, o_carry, i_carry && r_digit == i_max)

endmodule

/* rtl/stopwatch_with_lap_core.sv */
// Stopwatch core with lap capture, mm:ss.cc digits held in a chain of cells.
// Latency: a result word is shown the cycle after its input word is taken.
// Throughput: one word per clock while the sink accepts; the output register is
// refilled in the same cycle it is drained, so a ready sink never sees a gap.
// Reset (i_rst_n low at a clock edge): count, lap, run flag and output valid cleared.
`timescale 1ns / 1ps
`include "stopwatch_with_lap_core_macros.svh"

module stopwatch_with_lap_core import swl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] tick [1] start_key [2] stop_key
                                     // [3] lap_key [4] clear_key [7:5] zero
    input  logic        i_s_tuser,   // [0] show_lap
    // result word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [6:0] minutes [12:7] seconds
                                     // [19:13] centiseconds [20] running
                                     // [23:21] zero
);

    // Key decode
    logic w_tick, w_start, w_stop, w_lap, w_clear;
    assign w_tick  = i_s_tdata[0];
    assign w_start = i_s_tdata[1];
    assign w_stop  = i_s_tdata[2];
    assign w_lap   = i_s_tdata[3];
    assign w_clear = i_s_tdata[4];

    logic r_run, n_run;
    logic r_valid;
    logic r_show;
    logic w_accept;

    // Output register drains and refills in the same cycle.
    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Control priority: stop while running, then start alone while stopped,
    // then clear. Clear only acts when neither of the first two fired.
    logic w_do_stop, w_do_start, w_do_clear;
    assign w_do_stop  = r_run && w_stop;
    assign w_do_start = !r_run && w_start && !w_stop && !w_lap && !w_clear;
    assign w_do_clear = !w_do_stop && !w_do_start && w_clear;

    always_comb begin
        priority if (w_do_stop) begin
            n_run = 1'b0;
        end else if (w_do_start) begin
            n_run = 1'b1;
        end else if (w_do_clear) begin
            n_run = 1'b0;
        end else begin
            n_run = r_run;
        end
    end

    t_cell_ctl w_ctl;
    assign w_ctl.en    = w_accept;
    assign w_ctl.lap   = w_lap;
    assign w_ctl.clear = w_do_clear;

    // Digit chain: centiseconds -> seconds -> minutes. The count only advances
    // on a tick seen while running (old run flag); minutes wrap at 99:59.99.
    logic [NUM_CELLS:0]   w_carry;
    logic [DIGIT_W-1:0]   w_digit [NUM_CELLS];
    logic [DIGIT_W-1:0]   w_lapd  [NUM_CELLS];

    assign w_carry[0] = w_accept && r_run && w_tick;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        swl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_max   (CELL_MAX[g]),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g]),
            .o_lap   (w_lapd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_run <= n_run;
            end
            if (o_s_tready) begin
                r_valid <= i_s_tvalid;
            end
        end
    end

    // Display select is payload; captured with the word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_show <= i_s_tuser;
        end
    end

    // Cells only change on accept, which also drains the held word, so the
    // cell registers serve directly as the result payload.
    logic [DIGIT_W-1:0] w_mm, w_ss, w_cs;
    assign w_mm = r_show ? w_lapd[CELL_MM] : w_digit[CELL_MM];
    assign w_ss = r_show ? w_lapd[CELL_SS] : w_digit[CELL_SS];
    assign w_cs = r_show ? w_lapd[CELL_CS] : w_digit[CELL_CS];

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {3'b000, r_run, w_cs, w_ss[5:0], w_mm};

    `SWL_ASSERT_NXT(a_stop_wins, w_accept && r_run && w_stop, !r_run)
    `SWL_ASSERT_NXT(a_result_follows, w_accept, o_m_tvalid)
    `SWL_ASSERT_NXT(a_clear_zeroes, w_accept && w_do_clear,
                    !r_run && w_digit[CELL_CS] == '0 && w_lapd[CELL_CS] == '0)

endmodule

/* tb/tb_stopwatch_with_lap_core.sv */
`timescale 1ns / 1ps

module tb_stopwatch_with_lap_core;

    // time base, in hundredths of a second
    localparam int CS_PER_SEC  = 100;
    localparam int CS_PER_MIN  = 6000;
    localparam int SEC_PER_MIN = 60;
    localparam int MIN_WRAP    = 100;
    localparam int COUNT_WRAP  = 600000;   // 100:00.00 rolls back to zero

    // one stretch of ticks long enough to carry centiseconds into seconds
    localparam int LONG_RUN_TICKS = 120;
    localparam int RAND_WORDS     = 500;
    localparam int NUM_PHASES     = 4;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic tick;
        logic start_key;
        logic stop_key;
        logic lap_key;
        logic clear_key;
        logic show_lap;
    } key_word_t;

    typedef struct packed {
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [6:0] centis;
        logic       running;
    } display_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] o_m_tdata;

    key_word_t   s_word = '0;       // word currently on the input bus
    key_word_t   key_queue[$];      // words waiting to be driven
    display_t    display_queue[$];  // displays still owed by the core
    display_t    seen;
    display_t    owed;

    // predicted core state
    int          sw_count;
    int          sw_lap;
    logic        sw_running;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          fail_count     = 0;

    // tdata: [0] tick [1] start_key [2] stop_key [3] lap_key [4] clear_key [7:5] zero
    assign s_tdata = {3'b000, s_word.clear_key, s_word.lap_key, s_word.stop_key,
                      s_word.start_key, s_word.tick};
    // tuser: [0] show_lap
    assign s_tuser = s_word.show_lap;

    stopwatch_with_lap_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Applies one key word to the predicted state, returns what the display shows.
    // Order: tick, lap capture, then stop > lone start > clear.
    function automatic display_t stopwatch_advance(key_word_t k);
        display_t r;
        int       shown;
        if (sw_running && k.tick) begin
            sw_count = (sw_count + 1 >= COUNT_WRAP) ? 0 : sw_count + 1;
        end
        if (k.lap_key) begin
            sw_lap = sw_count;
        end
        if (sw_running && k.stop_key) begin
            sw_running = 1'b0;
        end else if (!sw_running && k.start_key && !k.stop_key && !k.lap_key
                     && !k.clear_key) begin
            sw_running = 1'b1;
        end else if (k.clear_key) begin
            sw_running = 1'b0;
            sw_count   = 0;
            sw_lap     = 0;
        end
        shown      = k.show_lap ? sw_lap : sw_count;
        r.minutes  = 7'((shown / CS_PER_MIN) % MIN_WRAP);
        r.seconds  = 6'((shown / CS_PER_SEC) % SEC_PER_MIN);
        r.centis   = 7'(shown % CS_PER_SEC);
        r.running  = sw_running;
        return r;
    endfunction

    task automatic push_keys(logic tick, logic start_key, logic stop_key, logic lap_key,
                             logic clear_key, logic show_lap);
        key_queue.push_back('{tick, start_key, stop_key, lap_key, clear_key, show_lap});
    endtask

    // blocks until every queued word has been taken by the core
    task automatic wait_keys_taken();
        while (key_queue.size() != 0 || s_tvalid) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: a word is taken on tvalid && tready; the prediction is made then,
    // from the word still on the bus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                display_queue.push_back(stopwatch_advance(s_word));
            end
            if (!s_tvalid || o_s_tready) begin
                if (key_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_word   <= key_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, each display word checked against the oldest owed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                seen = '{o_m_tdata[6:0], o_m_tdata[12:7], o_m_tdata[19:13], o_m_tdata[20]};
                if (display_queue.size() == 0) begin
                    $error("display word with none owed: %h", o_m_tdata);
                    fail_count++;
                end else begin
                    owed = display_queue.pop_front();
                    if (seen.minutes !== owed.minutes) begin
                        $error("minutes: expected %0d, got %0d", owed.minutes, seen.minutes);
                        fail_count++;
                    end
                    if (seen.seconds !== owed.seconds) begin
                        $error("seconds: expected %0d, got %0d", owed.seconds, seen.seconds);
                        fail_count++;
                    end
                    if (seen.centis !== owed.centis) begin
                        $error("centiseconds: expected %0d, got %0d", owed.centis,
                               seen.centis);
                        fail_count++;
                    end
                    if (seen.running !== owed.running) begin
                        $error("running: expected %0d, got %0d", owed.running,
                               seen.running);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus and end of run.
    initial begin
        sw_count   = 0;
        sw_lap     = 0;
        sw_running = 1'b0;
        i_rst_n    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset view, key combinations, priority corners
        //         tick start stop lap clr show
        push_keys(0,   0,    0,   0,  0,  0);   // idle after reset
        push_keys(1,   0,    0,   0,  0,  1);   // tick while stopped does nothing
        push_keys(0,   1,    1,   0,  0,  0);   // start with stop: ignored
        push_keys(1,   1,    0,   1,  0,  1);   // start with lap: ignored, lap takes zero
        push_keys(0,   1,    0,   0,  1,  0);   // start with clear: clear wins
        push_keys(0,   1,    0,   0,  0,  0);   // lone start
        push_keys(1,   0,    0,   0,  0,  0);
        push_keys(1,   1,    0,   0,  0,  0);   // start while running: no effect
        push_keys(1,   0,    0,   0,  0,  1);
        push_keys(1,   0,    0,   1,  0,  1);   // lap after the tick is counted
        push_keys(1,   0,    0,   0,  0,  0);
        push_keys(1,   0,    1,   0,  1,  0);   // stop and clear while running: stop wins
        push_keys(1,   0,    0,   0,  0,  1);   // stopped, lap still held
        push_keys(0,   0,    0,   0,  1,  1);   // clear while stopped zeroes both
        push_keys(0,   0,    0,   0,  0,  0);
        push_keys(0,   1,    0,   0,  0,  0);
        push_keys(1,   0,    0,   0,  0,  0);
        push_keys(1,   0,    0,   1,  1,  1);   // lap and clear: captured then zeroed
        push_keys(0,   1,    0,   0,  0,  0);
        push_keys(1,   1,    1,   1,  1,  1);   // every key at once while running
        push_keys(0,   0,    0,   0,  1,  0);

        // one run past a full second, with sparse lap captures
        push_keys(0, 1, 0, 0, 0, 0);
        for (int i = 0; i < LONG_RUN_TICKS; i++) begin
            push_keys(1, 0, 0, ($urandom_range(29) == 0), 0, $urandom_range(1));
        end
        push_keys(0, 0, 1, 0, 0, 1);
        push_keys(0, 0, 0, 0, 1, 0);
        wait_keys_taken();

        // random words, mostly ticks with occasional key presses, per idling phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int i = 0; i < RAND_WORDS / NUM_PHASES; i++) begin
                push_keys($urandom_range(99) < 75, $urandom_range(99) < 14,
                          $urandom_range(99) < 8, $urandom_range(99) < 10,
                          $urandom_range(99) < 5, $urandom_range(1));
            end
            wait_keys_taken();
        end

        while (display_queue.size() != 0) @(posedge i_clk);
        // catch any stray display word after the last owed one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_stopwatch_with_lap_core passed");
        end else begin
            $display("tb_stopwatch_with_lap_core failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("tb_stopwatch_with_lap_core failed");
        $finish;
    end

endmodule
